FILE: rtl/core/wdnp_pkg.sv
// Shared constants for the window density nearest peak block.
`timescale 1ns / 1ps
`default_nettype none

package wdnp_pkg;

    // Fractional bits of the Q15.8 coordinate format.
    localparam int FRAC_BITS = 8;

    // Configuration register widths.
    localparam int WW_W  = 13;
    localparam int TOP_W = 11;

    // Width of the window count field in a result word.
    localparam int CNT_OUT_W = 11;

    // Half window in Q15.8: (width >> 1) << FRAC_BITS.
    localparam int HALF_W = WW_W - 1 + FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WINDOW_WIDTH = 2'd0;
    localparam cfg_idx_t REG_TOP_COUNT    = 2'd1;
    localparam cfg_idx_t REG_REF_X        = 2'd2;
    localparam cfg_idx_t REG_REF_Y        = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/wdnp_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wdnp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/window_density_nearest_peak.sv
// Top level of the window density nearest peak block.
`timescale 1ns / 1ps
`default_nettype none

// Points arrive one word per cycle on the slave stream and are written into
// the coordinate memories while s_tready is high. The word with tlast set
// closes the set: the block then drops s_tready and runs its counting pass,
// where every stored point is compared against every stored point, itself
// included, through one shared pair of absolute difference units, one memory
// read a cycle. The ranking pass follows with the same shape, plus the
// distance steps D1, D2 and D3 on the shared multiplier for each of the top
// candidates; then the output register is loaded. The result sits in an
// output register, and loading of the next set starts at once; a second set
// can only finish once the previous result has been taken.
// Points beyond MAX_POINTS are dropped, but their tlast still ends the set.
// A top_count of zero acts as one. The memories need no clearing after reset.

module window_density_nearest_peak
    import wdnp_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // Point words. tdata: point_x, point_y, zero fill.
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire                     s_tlast,
    // Result words. tdata: source_x, source_y, window_count, zero fill.
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [((2*COORD_WIDTH+CNT_OUT_W+7)/8)*8-1:0] m_tdata,
    // Register writes.
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [((COORD_WIDTH > WW_W) ? COORD_WIDTH : WW_W)-1:0] cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = ((2*CW+CNT_OUT_W+7)/8)*8;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int N_W    = $clog2(MAX_POINTS+1);
    localparam int AD_W   = CW + 1;
    localparam int CMP_W  = (AD_W > HALF_W) ? AD_W : HALF_W;
    localparam int PW     = 2*AD_W;
    localparam int SQ_W   = (PW > 64) ? 64 : PW;
    localparam int SUM_W  = (SQ_W + 1 > 64) ? 64 : SQ_W + 1;
    localparam int RK_W   = (N_W > TOP_W) ? N_W : TOP_W;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CI_RD  = 4'd1;
    localparam logic [3:0] S_CI_LAT = 4'd2;
    localparam logic [3:0] S_CJ     = 4'd3;
    localparam logic [3:0] S_CJ_END = 4'd4;
    localparam logic [3:0] S_RI_RD  = 4'd5;
    localparam logic [3:0] S_RI_LAT = 4'd6;
    localparam logic [3:0] S_RJ     = 4'd7;
    localparam logic [3:0] S_RJ_END = 4'd8;
    localparam logic [3:0] S_D1     = 4'd9;
    localparam logic [3:0] S_D2     = 4'd10;
    localparam logic [3:0] S_D3     = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;

    // Configuration registers.
    logic [WW_W-1:0]  ww_reg;
    logic [TOP_W-1:0] top_reg;
    logic signed [CW-1:0] refx_reg, refy_reg;

    // Sequencer state.
    logic [3:0]     state_reg, state_next;
    logic [N_W-1:0] loaded_reg, loaded_next;
    logic [N_W-1:0] n_reg, n_next;
    logic [N_W-1:0] i_reg, i_next;
    logic [N_W-1:0] j_reg, j_next;
    logic [N_W-1:0] jd_reg;
    logic           pv_reg, pv_next;
    logic [N_W-1:0] acc_reg, acc_next;
    logic [N_W-1:0] ci_reg, ci_next;
    logic [N_W-1:0] rank_reg, rank_next;
    logic           found_reg, found_next;
    logic           ovalid_reg, ovalid_next;

    // Datapath registers.
    logic signed [CW-1:0] ax_reg, ay_reg, ax_next, ay_next;
    logic [SQ_W-1:0]      p_reg, sx_reg;
    logic [SUM_W-1:0]     bestd_reg, bestd_next;
    logic [N_W-1:0]       bestr_reg, bestr_next;
    logic signed [CW-1:0] bestx_reg, besty_reg, bestx_next, besty_next;
    logic [N_W-1:0]       bestc_reg, bestc_next;
    logic [OUT_W-1:0]     odata_reg, odata_next;

    // Memory ports.
    logic [CW-1:0]    x_rdata, y_rdata;
    logic [N_W-1:0]   c_rdata, c_wdata;
    logic [IDX_W-1:0] rd_addr, xy_waddr;
    logic             xy_we, c_we;

    logic in_acc, out_acc, last_j, hit, ranks_ahead;
    logic signed [CW-1:0] bx, by;
    logic signed [AD_W-1:0] dxs, dys;
    logic [AD_W-1:0] adx, ady, mop;
    logic [PW-1:0]   prod;
    logic [HALF_W-1:0] half;
    logic [SQ_W:0]   dsum;
    logic [SUM_W-1:0] dsq;
    logic [RK_W-1:0] k_ext, rank_f_ext;
    logic [N_W-1:0]  rank_f;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ww_reg   <= WW_W'(130);
            top_reg  <= TOP_W'(25);
            refx_reg <= '0;
            refy_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH: ww_reg   <= cfg_data[WW_W-1:0];
                REG_TOP_COUNT:    top_reg  <= cfg_data[TOP_W-1:0];
                REG_REF_X:        refx_reg <= cfg_data[CW-1:0];
                REG_REF_Y:        refy_reg <= cfg_data[CW-1:0];
                default:          ;
            endcase
        end
    end

    // Point storage.
    wdnp_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x_ram (
        .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(s_tdata[CW-1:0]),
        .raddr(rd_addr), .rdata(x_rdata)
    );
    wdnp_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y_ram (
        .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(s_tdata[2*CW-1:CW]),
        .raddr(rd_addr), .rdata(y_rdata)
    );
    wdnp_ram #(.WIDTH(N_W), .DEPTH(MAX_POINTS)) u_c_ram (
        .clk(clk), .we(c_we), .waddr(i_reg[IDX_W-1:0]), .wdata(c_wdata),
        .raddr(rd_addr), .rdata(c_rdata)
    );

    assign xy_we    = in_acc && (loaded_reg < N_W'(MAX_POINTS));
    assign xy_waddr = loaded_reg[IDX_W-1:0];
    assign rd_addr  = (state_reg == S_CI_RD || state_reg == S_RI_RD) ?
                      i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];

    // Shared absolute difference lanes: against a stored point in the
    // counting pass, against the reference during the distance steps.
    assign bx  = (state_reg == S_D1 || state_reg == S_D2) ? refx_reg : $signed(x_rdata);
    assign by  = (state_reg == S_D1 || state_reg == S_D2) ? refy_reg : $signed(y_rdata);
    assign dxs = AD_W'(ax_reg) - AD_W'(bx);
    assign dys = AD_W'(ay_reg) - AD_W'(by);
    assign adx = dxs[AD_W-1] ? AD_W'(-dxs) : AD_W'(dxs);
    assign ady = dys[AD_W-1] ? AD_W'(-dys) : AD_W'(dys);

    assign half = {ww_reg[WW_W-1:1], FRAC_BITS'(0)};
    assign hit  = (CMP_W'(adx) <= CMP_W'(half)) && (CMP_W'(ady) <= CMP_W'(half));

    // Shared squarer; its product is registered before the sum.
    assign mop  = (state_reg == S_D1) ? adx : ady;
    assign prod = PW'(mop) * PW'(mop);
    assign dsum = {1'b0, sx_reg} + {1'b0, p_reg};
    assign dsq  = ((SQ_W == 64) && dsum[SQ_W]) ? {SUM_W{1'b1}} : SUM_W'(dsum);

    // Rank test of the count word addressed on the previous cycle (index jd_reg) against point i.
    assign ranks_ahead = (c_rdata > ci_reg) || ((c_rdata == ci_reg) && (jd_reg < i_reg));
    assign rank_f = rank_reg + N_W'(pv_reg && ranks_ahead);
    assign k_ext  = (top_reg == '0) ? RK_W'(1) : RK_W'(top_reg);
    assign rank_f_ext = RK_W'(rank_f);

    assign last_j  = (j_reg == n_reg - N_W'(1));
    assign c_we    = (state_reg == S_CJ_END);
    assign c_wdata = acc_reg + N_W'(pv_reg && hit);

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pv_next     = 1'b0;
        acc_next    = acc_reg;
        ci_next     = ci_reg;
        rank_next   = rank_reg;
        found_next  = found_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        bestd_next  = bestd_reg;
        bestr_next  = bestr_reg;
        bestx_next  = bestx_reg;
        besty_next  = besty_reg;
        bestc_next  = bestc_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !out_acc;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (xy_we)
                    begin
                        loaded_next = loaded_reg + N_W'(1);
                    end
                    if (s_tlast)
                    begin
                        n_next      = loaded_next;
                        loaded_next = '0;
                        i_next      = '0;
                        state_next  = S_CI_RD;
                    end
                end
            end
            S_CI_RD:  state_next = S_CI_LAT;
            S_CI_LAT:
            begin
                ax_next    = x_rdata;
                ay_next    = y_rdata;
                acc_next   = '0;
                j_next     = '0;
                state_next = S_CJ;
            end
            S_CJ:
            begin
                acc_next = acc_reg + N_W'(pv_reg && hit);
                pv_next  = 1'b1;
                j_next   = j_reg + N_W'(1);
                if (last_j)
                begin
                    state_next = S_CJ_END;
                end
            end
            S_CJ_END:
            begin
                i_next = i_reg + N_W'(1);
                if (i_next == n_reg)
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = S_RI_RD;
                end
                else
                begin
                    state_next = S_CI_RD;
                end
            end
            S_RI_RD:  state_next = S_RI_LAT;
            S_RI_LAT:
            begin
                ax_next    = x_rdata;
                ay_next    = y_rdata;
                ci_next    = c_rdata;
                rank_next  = '0;
                j_next     = '0;
                state_next = S_RJ;
            end
            S_RJ:
            begin
                rank_next = rank_f;
                pv_next   = 1'b1;
                j_next    = j_reg + N_W'(1);
                if (last_j)
                begin
                    state_next = S_RJ_END;
                end
            end
            S_RJ_END:
            begin
                rank_next = rank_f;
                if (rank_f_ext < k_ext)
                begin
                    state_next = S_D1;
                end
                else
                begin
                    i_next     = i_reg + N_W'(1);
                    state_next = (i_next == n_reg) ? S_FIN : S_RI_RD;
                end
            end
            S_D1:     state_next = S_D2;
            S_D2:     state_next = S_D3;
            S_D3:
            begin
                if (!found_reg || dsq < bestd_reg ||
                    (dsq == bestd_reg && rank_reg < bestr_reg))
                begin
                    found_next = 1'b1;
                    bestd_next = dsq;
                    bestr_next = rank_reg;
                    bestx_next = ax_reg;
                    besty_next = ay_reg;
                    bestc_next = ci_reg;
                end
                i_next     = i_reg + N_W'(1);
                state_next = (i_next == n_reg) ? S_FIN : S_RI_RD;
            end
            S_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    odata_next  = OUT_W'({CNT_OUT_W'(bestc_reg), besty_reg, bestx_reg});
                    ovalid_next = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            loaded_reg <= '0;
            pv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            pv_reg     <= pv_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        jd_reg    <= j_reg;
        acc_reg   <= acc_next;
        ci_reg    <= ci_next;
        rank_reg  <= rank_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        p_reg     <= prod[SQ_W-1:0];
        if (state_reg == S_D2)
        begin
            sx_reg <= p_reg;
        end
        bestd_reg <= bestd_next;
        bestr_reg <= bestr_next;
        bestx_reg <= bestx_next;
        besty_reg <= besty_next;
        bestc_reg <= bestc_next;
        odata_reg <= odata_next;
    end

    // A finished set always has at least one candidate.
    a_found_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> found_reg)
        else $error("no candidate chosen at end of set");

    // A window count covers the point itself and never exceeds the set size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CJ_END) |-> (c_wdata != '0 && c_wdata <= n_reg))
        else $error("window count out of range");

    // Distance steps only run for points ranked inside the top set.
    a_rank_in_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D1) |-> (RK_W'(rank_reg) < k_ext))
        else $error("distance computed for a point outside the top set");

    // The fill count never passes the memory depth.
    a_loaded_max: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= N_W'(MAX_POINTS))
        else $error("point count exceeds memory depth");

endmodule

`default_nettype wire
